/* rtl/exptok_pkg.sv */
`default_nettype none
package exptok_pkg;

    // lexer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;
    localparam logic [1:0] MODE_EQ   = 2'd3;

    // token kinds
    localparam logic [3:0] K_NUM     = 4'd0;
    localparam logic [3:0] K_WORD    = 4'd1;
    localparam logic [3:0] K_LESS    = 4'd2;
    localparam logic [3:0] K_GREATER = 4'd3;
    localparam logic [3:0] K_ADD     = 4'd4;
    localparam logic [3:0] K_SUB     = 4'd5;
    localparam logic [3:0] K_MUL     = 4'd6;
    localparam logic [3:0] K_DIV     = 4'd7;
    localparam logic [3:0] K_SEP     = 4'd8;
    localparam logic [3:0] K_EQUAL   = 4'd9;
    localparam logic [3:0] K_ASSIGN  = 4'd10;
    localparam logic [3:0] K_ERROR   = 4'd11;

    // characters of interest
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_ADD     = 8'h2B;
    localparam logic [7:0] CH_SUB     = 8'h2D;
    localparam logic [7:0] CH_MUL     = 8'h2A;
    localparam logic [7:0] CH_DIV     = 8'h2F;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] out_byte;
        logic       first_of_token;
        logic       last_of_token;
    } t_result;

    // results of one lexed item, slot 1 only used with slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_lex_out;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage
`default_nettype wire

/* rtl/exptok_if.sv */
`default_nettype none
// input channel: one character or end marker per item
interface exptok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

// output channel: one token byte per item
interface exptok_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] out_byte;
    logic       first_of_token;
    logic       last_of_token;

    modport source (output valid, output token_kind, output out_byte,
                    output first_of_token, output last_of_token, input ready);
    modport sink   (input valid, input token_kind, input out_byte,
                    input first_of_token, input last_of_token, output ready);
endinterface
`default_nettype wire

/* rtl/exptok_lexer.sv */
`default_nettype none
module exptok_lexer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic [7:0]            i_char_byte,
    input  wire logic                  i_end_of_input,
    output exptok_pkg::t_lex_out       o_res
);
    import exptok_pkg::*;

    logic [1:0] r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_first, n_first;

    t_result    flush_r, idle_r;
    logic       flush_v, idle_v;
    logic [7:0] c;

    assign c = i_char_byte;

    // pending token closed with a last mark
    always_comb begin
        flush_v = (r_mode != MODE_IDLE);
        flush_r = '{token_kind: K_NUM, out_byte: r_held,
                    first_of_token: r_first, last_of_token: 1'b1};
        unique case (r_mode)
            MODE_WORD: flush_r.token_kind = K_WORD;
            MODE_EQ: begin
                flush_r = '{token_kind: K_ASSIGN, out_byte: CH_EQ,
                            first_of_token: 1'b1, last_of_token: 1'b1};
            end
            default: flush_r.token_kind = K_NUM;
        endcase
    end

    // single-byte tokens and errors lexed from idle
    always_comb begin
        idle_v = 1'b1;
        idle_r = '{token_kind: K_ERROR, out_byte: c,
                   first_of_token: 1'b1, last_of_token: 1'b1};
        if (is_blank(c) || is_digit(c) || is_letter(c) || (c == CH_EQ)) begin
            idle_v = 1'b0;
        end else if (c == CH_LESS) begin
            idle_r.token_kind = K_LESS;
        end else if (c == CH_GREATER) begin
            idle_r.token_kind = K_GREATER;
        end else if (c == CH_ADD) begin
            idle_r.token_kind = K_ADD;
        end else if (c == CH_SUB) begin
            idle_r.token_kind = K_SUB;
        end else if (c == CH_MUL) begin
            idle_r.token_kind = K_MUL;
        end else if (c == CH_DIV) begin
            idle_r.token_kind = K_DIV;
        end else if ((c == CH_COMMA) || (c == CH_SEMI) || (c == CH_LBRACE) ||
                     (c == CH_RBRACE) || (c == CH_LPAREN) || (c == CH_RPAREN)) begin
            idle_r.token_kind = K_SEP;
        end
    end

    // next state and results of this item
    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_first = r_first;
        o_res   = '{v0: 1'b0, v1: 1'b0, r0: flush_r, r1: idle_r};
        priority if (i_end_of_input) begin
            o_res.v0 = flush_v;
            n_mode   = MODE_IDLE;
            n_held   = 8'h00;
            n_first  = 1'b0;
        end else if ((r_mode == MODE_NUM) && is_digit(c)) begin
            o_res.v0                = 1'b1;
            o_res.r0.last_of_token  = 1'b0;
            n_held                  = c;
            n_first                 = 1'b0;
        end else if ((r_mode == MODE_WORD) && (is_digit(c) || is_letter(c))) begin
            o_res.v0                = 1'b1;
            o_res.r0.last_of_token  = 1'b0;
            n_held                  = c;
            n_first                 = 1'b0;
        end else if ((r_mode == MODE_EQ) && (c == CH_EQ)) begin
            o_res.v0 = 1'b1;
            o_res.r0 = '{token_kind: K_EQUAL, out_byte: CH_EQ,
                         first_of_token: 1'b1, last_of_token: 1'b1};
            n_mode   = MODE_IDLE;
            n_held   = 8'h00;
            n_first  = 1'b0;
        end else begin
            // close anything pending, then lex the byte afresh
            if (flush_v) begin
                o_res.v0 = 1'b1;
                o_res.v1 = idle_v;
            end else begin
                o_res.v0 = idle_v;
                o_res.r0 = idle_r;
            end
            n_mode  = MODE_IDLE;
            n_held  = 8'h00;
            n_first = 1'b0;
            if (is_digit(c)) begin
                n_mode  = MODE_NUM;
                n_held  = c;
                n_first = 1'b1;
            end else if (is_letter(c)) begin
                n_mode  = MODE_WORD;
                n_held  = c;
                n_first = 1'b1;
            end else if (c == CH_EQ) begin
                n_mode  = MODE_EQ;
                n_held  = CH_EQ;
                n_first = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= 8'h00;
            r_first <= 1'b0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_first <= n_first;
        end
    end

    // end marker always leaves the lexer idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_end_of_input) |=> (r_mode == MODE_IDLE))
        else $error("lexer not idle after end of input");

    // a second result only follows a first one
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.v1 |-> o_res.v0)
        else $error("second result without first");

    // a held continuation byte of a number is never marked first
    a_cont_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_end_of_input && (r_mode == MODE_NUM) && is_digit(c))
        |=> !r_first)
        else $error("continuation byte marked first");

endmodule
`default_nettype wire

/* rtl/expression_tokenizer_top.sv */
`default_nettype none
// Expression tokenizer.
// Input channel i_in: one item per character (char_byte) or an end marker
// (end_of_input set, char_byte ignored). Output channel o_out: one item per
// token byte with its kind and first/last marks.
// Each input item is lexed in the cycle it is accepted and its zero, one or
// two results go into a four-entry result queue; when the queue was empty,
// the first result is visible on o_out in the next cycle. Digits, letters
// and '=' are held back one item, so their result appears when the
// following item is accepted. Input is accepted whenever the queue has two
// free entries, so one character per cycle is sustained while o_out drains
// one item per cycle; a character that closes a token and
// starts an operator gives two results and so two output items.
// When the receiver stalls, the queue fills and i_in.ready drops until
// entries are taken; nothing is lost.
// Reset (i_rst_n low, synchronous) empties the queue and returns the lexer
// to idle with nothing pending.
module expression_tokenizer_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    exptok_in_if.sink    i_in,
    exptok_out_if.source o_out
);
    import exptok_pkg::*;

    t_lex_out         lex_res;
    logic             in_acc, out_acc;
    logic [1:0]       push_n;

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign push_n  = in_acc ? ({1'b0, lex_res.v0} + {1'b0, lex_res.v1}) : 2'd0;

    exptok_lexer u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (in_acc),
        .i_char_byte    (i_in.char_byte),
        .i_end_of_input (i_in.end_of_input),
        .o_res          (lex_res)
    );

    // room for the worst case of two results
    assign i_in.ready = (r_count <= CNT_W'(FIFO_DEPTH - 2));

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && lex_res.v0) begin
            r_mem[r_wptr] <= lex_res.r0;
        end
        if (in_acc && lex_res.v1) begin
            r_mem[r_wptr + PTR_W'(1)] <= lex_res.r1;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(push_n);
            r_rptr  <= r_rptr + PTR_W'(out_acc);
            r_count <= r_count + CNT_W'(push_n) - CNT_W'(out_acc);
        end
    end

    // queue head drives the output
    assign o_out.valid          = (r_count != '0);
    assign o_out.token_kind     = r_mem[r_rptr].token_kind;
    assign o_out.out_byte       = r_mem[r_rptr].out_byte;
    assign o_out.first_of_token = r_mem[r_rptr].first_of_token;
    assign o_out.last_of_token  = r_mem[r_rptr].last_of_token;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n == 2'd2 && !out_acc) |=> (r_count == $past(r_count) + CNT_W'(2)))
        else $error("fill count lost a double push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

/* bench/expression_tokenizer_top_tb.sv */
`default_nettype none
module expression_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import exptok_pkg::*;

    localparam int ITEMS_PER_PHASE = 120;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 20;

    // one-byte operators and separators
    localparam logic [7:0] OP_CHARS [12] = '{
        CH_LESS, CH_GREATER, CH_ADD, CH_SUB, CH_MUL, CH_DIV,
        CH_COMMA, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN
    };

    // directed opening: {end flag, character}
    localparam int N_DIRECTED = 29;
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        {1'b0, 8'h30}, {1'b0, 8'h39}, {1'b0, 8'h61}, {1'b0, 8'h5A},
        {1'b0, CH_EQ}, {1'b0, CH_EQ}, {1'b0, CH_EQ}, {1'b0, CH_LESS},
        {1'b0, CH_GREATER}, {1'b0, CH_ADD}, {1'b0, CH_SUB}, {1'b0, CH_MUL},
        {1'b0, CH_DIV}, {1'b0, CH_COMMA}, {1'b0, CH_SEMI}, {1'b0, CH_LBRACE},
        {1'b0, CH_RBRACE}, {1'b0, CH_LPAREN}, {1'b0, CH_RPAREN},
        {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_SPACE}, {1'b0, 8'h7A},
        {1'b1, 8'hA5}, {1'b0, CH_EQ}, {1'b1, 8'h5A}, {1'b0, 8'h37},
        {1'b1, 8'hFF}, {1'b1, 8'h00}
    };

    // token predictor and store of expected token bytes
    class token_scoreboard;
        t_result    expected_tokens[$];
        logic [1:0] mode;
        logic [7:0] held;
        logic       held_first;
        int         mismatches;

        function new();
            mode       = MODE_IDLE;
            held       = 8'h00;
            held_first = 1'b0;
            mismatches = 0;
        endfunction

        function bit digit_char(input logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function bit letter_char(input logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit blank_char(input logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit op_kind(input logic [7:0] c, output logic [3:0] k);
            op_kind = 1'b1;
            case (c)
                CH_LESS:    k = K_LESS;
                CH_GREATER: k = K_GREATER;
                CH_ADD:     k = K_ADD;
                CH_SUB:     k = K_SUB;
                CH_MUL:     k = K_MUL;
                CH_DIV:     k = K_DIV;
                CH_COMMA, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN:
                    k = K_SEP;
                default: begin
                    k = K_ERROR;
                    op_kind = 1'b0;
                end
            endcase
        endfunction

        function void push(input logic [3:0] k, input logic [7:0] c,
                           input logic f, input logic l);
            t_result r;
            r.token_kind     = k;
            r.out_byte       = c;
            r.first_of_token = f;
            r.last_of_token  = l;
            expected_tokens = {expected_tokens, r};
        endfunction

        // close whatever is held with a last mark
        function void flush_pending();
            if (mode == MODE_NUM)
                push(K_NUM, held, held_first, 1'b1);
            else if (mode == MODE_WORD)
                push(K_WORD, held, held_first, 1'b1);
            else if (mode == MODE_EQ)
                push(K_ASSIGN, CH_EQ, 1'b1, 1'b1);
            mode       = MODE_IDLE;
            held       = 8'h00;
            held_first = 1'b0;
        endfunction

        function void lex_from_idle(input logic [7:0] c);
            logic [3:0] k;
            if (blank_char(c))
                return;
            if (digit_char(c) || letter_char(c) || c == CH_EQ) begin
                mode       = digit_char(c) ? MODE_NUM :
                             (c == CH_EQ) ? MODE_EQ : MODE_WORD;
                held       = c;
                held_first = 1'b1;
                return;
            end
            if (op_kind(c, k))
                push(k, c, 1'b1, 1'b1);
            else
                push(K_ERROR, c, 1'b1, 1'b1);
        endfunction

        // accepted input item
        function void note_char(input logic [7:0] c, input logic eoi);
            if (eoi) begin
                flush_pending();
            end else if (mode == MODE_NUM && digit_char(c)) begin
                push(K_NUM, held, held_first, 1'b0);
                held       = c;
                held_first = 1'b0;
            end else if (mode == MODE_WORD && (letter_char(c) || digit_char(c))) begin
                push(K_WORD, held, held_first, 1'b0);
                held       = c;
                held_first = 1'b0;
            end else if (mode == MODE_EQ && c == CH_EQ) begin
                push(K_EQUAL, CH_EQ, 1'b1, 1'b1);
                mode       = MODE_IDLE;
                held       = 8'h00;
                held_first = 1'b0;
            end else begin
                flush_pending();
                lex_from_idle(c);
            end
        endfunction

        task report(input string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // accepted result item against the oldest expectation
        task check_token(input t_result got);
            t_result want;
            if (expected_tokens.size() == 0) begin
                report($sformatf("unexpected kind=%0d byte=%02h f=%0b l=%0b",
                       got.token_kind, got.out_byte, got.first_of_token,
                       got.last_of_token));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.out_byte !== want.out_byte ||
                got.first_of_token !== want.first_of_token ||
                got.last_of_token !== want.last_of_token)
                report($sformatf({"got kind=%0d byte=%02h f=%0b l=%0b, ",
                                  "want kind=%0d byte=%02h f=%0b l=%0b"},
                       got.token_kind, got.out_byte, got.first_of_token,
                       got.last_of_token, want.token_kind, want.out_byte,
                       want.first_of_token, want.last_of_token));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    exptok_in_if  in_ch();
    exptok_out_if out_ch();

    expression_tokenizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    token_scoreboard sb = new();
    int  src_idle_pct = 34;
    int  snk_idle_pct = 76;
    int  items_sent   = 0;
    int  quiet_cycles = 0;

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: check accepted token bytes, stall at random
    initial begin
        t_result got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.token_kind     = out_ch.token_kind;
                got.out_byte       = out_ch.out_byte;
                got.first_of_token = out_ch.first_of_token;
                got.last_of_token  = out_ch.last_of_token;
                sb.check_token(got);
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // present one item; valid stays high afterwards until the next call or drain_wait
    task automatic send_item(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.char_byte    <= c;
        in_ch.end_of_input <= eoi;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        sb.note_char(c, eoi);
        items_sent++;
    endtask

    // hold off the sender until every expected token byte has arrived
    task automatic drain_wait();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_tokens.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
    endfunction

    // one lexeme of the expression language, now and then noise or end
    task automatic send_lexeme();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 25) begin
            len = $urandom_range(4, 1);
            repeat (len) send_item(rand_digit(), 1'b0);
        end else if (pick < 50) begin
            send_item(rand_letter(), 1'b0);
            len = $urandom_range(3);
            repeat (len)
                send_item($urandom_range(2) ? rand_letter() : rand_digit(), 1'b0);
        end else if (pick < 70) begin
            send_item(OP_CHARS[4'($urandom_range(11))], 1'b0);
        end else if (pick < 78) begin
            send_item(CH_EQ, 1'b0);
        end else if (pick < 84) begin
            send_item(CH_EQ, 1'b0);
            send_item(CH_EQ, 1'b0);
        end else if (pick < 92) begin
            len = $urandom_range(2, 1);
            repeat (len)
                send_item($urandom_range(2) ? CH_SPACE : 8'(8'h09 + $urandom_range(4)),
                          1'b0);
        end else if (pick < 96) begin
            send_item(8'($urandom_range(255)), 1'b0);
        end else begin
            send_item(8'($urandom_range(255)), 1'b1);
        end
    endtask

    // main sequence
    initial begin
        int target;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.char_byte    <= 8'h00;
        in_ch.end_of_input <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i])
            send_item(DIRECTED[i][7:0], DIRECTED[i][8]);
        drain_wait();

        // three idling phases: sender-light, receiver-light, none
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 76 : 0;
            snk_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 34 : 0;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                send_lexeme();
                if (items_sent > target - ITEMS_PER_PHASE / 2 && phase == 0 &&
                    $urandom_range(19) == 0)
                    drain_wait();
            end
            send_item(8'($urandom_range(255)), 1'b1);
            drain_wait();
        end

        snk_idle_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
